// ----- rtl/core/hfa_pkg.sv -----
// shared constants, codes and types of the hole fit allocator
`timescale 1ns / 1ps

package hfa_pkg;

   localparam int MAX_BLOCKS = 16;
   localparam int ADDR_BITS  = 16;
   localparam int ID_BITS    = 8;
   localparam int IDX_BITS   = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS   = $clog2(MAX_BLOCKS + 1);
   localparam int STS_BITS   = 3;

   localparam logic [ADDR_BITS-1:0] TOTAL_RESET = ADDR_BITS'(1024);

   localparam logic [STS_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STS_BITS-1:0] ST_TOO_BIG   = 3'd1;
   localparam logic [STS_BITS-1:0] ST_ID_EXISTS = 3'd2;
   localparam logic [STS_BITS-1:0] ST_NO_HOLE   = 3'd3;
   localparam logic [STS_BITS-1:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic                 command;
      logic [ID_BITS-1:0]   block_id;
      logic [ADDR_BITS-1:0] block_size;
   } req_type;

   typedef struct packed {
      logic [STS_BITS-1:0]  status;
      logic [ADDR_BITS-1:0] block_start;
      logic [ADDR_BITS-1:0] block_end;
      logic [ADDR_BITS-1:0] free_left;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0]   id;
      logic [ADDR_BITS-1:0] base;
      logic [ADDR_BITS-1:0] limit;
   } entry_type;

   typedef struct packed {
      logic load;
      logic check;
      logic scan;
      logic last;
      logic decide;
   } cmd_type;

   typedef struct packed {
      logic too_big;
      logic table_empty;
      logic scan_last;
   } sts_type;

endpackage

// ----- rtl/core/hfa_table.sv -----
// sorted block table with one read port and shift insert
`timescale 1ns / 1ps

module hfa_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clear,
   input  logic [hfa_pkg::IDX_BITS-1:0]      rd_idx,
   output hfa_pkg::entry_type                rd_data,
   input  logic                              ins_en,
   input  logic [hfa_pkg::CNT_BITS-1:0]      ins_pos,
   input  hfa_pkg::entry_type                ins_data,
   output logic [hfa_pkg::CNT_BITS-1:0]      count
);

   hfa_pkg::entry_type                 entry_ff [hfa_pkg::MAX_BLOCKS];
   logic [hfa_pkg::CNT_BITS-1:0]       count_ff;
   logic [hfa_pkg::CNT_BITS-1:0]       count_in;

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (ins_en) begin
         count_in = count_ff + hfa_pkg::CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // entries above the insert point move up by one in the same cycle
   always_ff @(posedge clock) begin
      if (ins_en) begin
         if (ins_pos == '0) begin
            entry_ff[0] <= ins_data;
         end
         for (int k = 1; k < hfa_pkg::MAX_BLOCKS; k++) begin
            if (hfa_pkg::CNT_BITS'(k) == ins_pos) begin
               entry_ff[k] <= ins_data;
            end else if (hfa_pkg::CNT_BITS'(k) > ins_pos &&
                         hfa_pkg::CNT_BITS'(k) <= count_ff) begin
               entry_ff[k] <= entry_ff[k-1];
            end
         end
      end
   end

   assign rd_data = entry_ff[rd_idx];
   assign count   = count_ff;

endmodule

// ----- rtl/core/hfa_datapath.sv -----
// request registers, hole evaluation, free amount and result register
`timescale 1ns / 1ps

module hfa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  hfa_pkg::cmd_type               cmd,
   output hfa_pkg::sts_type               sts,
   input  hfa_pkg::req_type               req_data,
   input  logic                           csr_we,
   input  logic [hfa_pkg::ADDR_BITS-1:0]  csr_wdata,
   output logic                           rsp_valid,
   output hfa_pkg::rsp_type               rsp_data
);

   localparam int AW = hfa_pkg::ADDR_BITS;
   localparam int IW = hfa_pkg::IDX_BITS;
   localparam int CW = hfa_pkg::CNT_BITS;

   hfa_pkg::req_type    req_ff;
   logic [AW-1:0]       total_ff;
   logic [AW-1:0]       free_ff;
   logic [AW-1:0]       free_in;
   logic [IW-1:0]       idx_ff;
   logic [AW-1:0]       prev_end_ff;
   logic                found_ff;
   logic                dup_ff;
   logic [IW-1:0]       chosen_ff;
   logic [AW-1:0]       best_hole_ff;
   logic [AW-1:0]       chosen_base_ff;
   hfa_pkg::rsp_type    rsp_ff;
   hfa_pkg::rsp_type    rsp_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;

   hfa_pkg::entry_type  rd_data;
   logic                ins_en;
   logic [CW-1:0]       ins_pos;
   hfa_pkg::entry_type  ins_data;
   logic [CW-1:0]       count;

   logic [AW-1:0]       hole_limit;
   logic [AW-1:0]       hole;
   logic                eval_hole;
   logic                take_hole;
   logic [IW-1:0]       hole_idx;
   logic [AW-1:0]       free_after;
   logic [hfa_pkg::STS_BITS-1:0] decide_status;

   hfa_table u_table (
      .clock    (clock),
      .reset    (reset),
      .clear    (csr_we),
      .rd_idx   (idx_ff),
      .rd_data  (rd_data),
      .ins_en   (ins_en),
      .ins_pos  (ins_pos),
      .ins_data (ins_data),
      .count    (count)
   );

   assign sts.too_big     = req_ff.block_size > free_ff;
   assign sts.table_empty = count == '0;
   assign sts.scan_last   = CW'(idx_ff) == count - CW'(1);

   // hole after the previous entry: up to this entry's base, or to the end of memory
   assign hole_limit = cmd.last ? total_ff : rd_data.base;
   assign hole       = (hole_limit >= prev_end_ff) ? hole_limit - prev_end_ff : '0;
   assign eval_hole  = cmd.last || (cmd.scan && idx_ff != '0);
   assign hole_idx   = cmd.last ? idx_ff : idx_ff - IW'(1);
   assign take_hole  = eval_hole && hole >= req_ff.block_size &&
                       (!found_ff || (req_ff.command && hole < best_hole_ff));

   assign free_after = free_ff - req_ff.block_size;

   always_comb begin
      if (dup_ff) begin
         decide_status = hfa_pkg::ST_ID_EXISTS;
      end else if (count == CW'(hfa_pkg::MAX_BLOCKS)) begin
         decide_status = hfa_pkg::ST_FULL;
      end else if (!found_ff) begin
         decide_status = hfa_pkg::ST_NO_HOLE;
      end else begin
         decide_status = hfa_pkg::ST_OK;
      end
   end

   always_comb begin
      ins_en         = 1'b0;
      ins_pos        = CW'(chosen_ff) + CW'(1);
      ins_data.id    = req_ff.block_id;
      ins_data.base  = chosen_base_ff;
      ins_data.limit = chosen_base_ff + req_ff.block_size;
      free_in        = free_ff;
      rsp_valid_in   = 1'b0;
      rsp_in.status      = hfa_pkg::ST_OK;
      rsp_in.block_start = '0;
      rsp_in.block_end   = '0;
      rsp_in.free_left   = free_ff;
      if (cmd.check) begin
         if (sts.too_big) begin
            rsp_valid_in  = 1'b1;
            rsp_in.status = hfa_pkg::ST_TOO_BIG;
         end else if (sts.table_empty) begin
            ins_en             = 1'b1;
            ins_pos            = '0;
            ins_data.base      = '0;
            ins_data.limit     = req_ff.block_size;
            free_in            = free_after;
            rsp_valid_in       = 1'b1;
            rsp_in.block_end   = req_ff.block_size;
            rsp_in.free_left   = free_after;
         end
      end else if (cmd.decide) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = decide_status;
         if (decide_status == hfa_pkg::ST_OK) begin
            ins_en             = 1'b1;
            free_in            = free_after;
            rsp_in.block_start = chosen_base_ff;
            rsp_in.block_end   = chosen_base_ff + req_ff.block_size;
            rsp_in.free_left   = free_after;
         end
      end
      if (csr_we) begin
         free_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= hfa_pkg::TOTAL_RESET;
         free_ff      <= hfa_pkg::TOTAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            total_ff <= csr_wdata;
         end
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff   <= req_data;
         idx_ff   <= '0;
         found_ff <= 1'b0;
         dup_ff   <= 1'b0;
      end
      if (cmd.scan) begin
         prev_end_ff <= rd_data.limit;
         if (rd_data.id == req_ff.block_id) begin
            dup_ff <= 1'b1;
         end
         if (!sts.scan_last) begin
            idx_ff <= idx_ff + IW'(1);
         end
      end
      if (take_hole) begin
         found_ff       <= 1'b1;
         chosen_ff      <= hole_idx;
         best_hole_ff   <= hole;
         chosen_base_ff <= prev_end_ff;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- rtl/core/hfa_controller.sv -----
// sequencing state machine of the allocator
`timescale 1ns / 1ps

module hfa_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  hfa_pkg::sts_type  sts,
   output hfa_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_LAST   = 3'd3;
   localparam logic [2:0] S_DECIDE = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            // oversize and empty-table requests finish here
            if (sts.too_big || sts.table_empty) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = S_LAST;
            end
         end
         S_LAST: begin
            cmd.last = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = state_ff != S_IDLE;

endmodule

// ----- rtl/core/hole_fit_allocator.sv -----
// top level of the first-fit / best-fit contiguous allocator
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Oversized requests and requests
// into an empty table finish in the check state; all others pass through the table scan,
// which reads one entry per cycle through a single read port and evaluates one hole
// per cycle, then the hole after the last entry and the decision. Each request gives
// exactly one result, shown on rsp_data for one cycle with rsp_valid high; the
// receiver cannot stall it and must take it in that cycle. A write to csr_wdata
// sets the memory size and empties the table; write only while busy is low.
module hole_fit_allocator (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  hfa_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output hfa_pkg::rsp_type               rsp_data,
   input  logic                           csr_we,
   input  logic [hfa_pkg::ADDR_BITS-1:0]  csr_wdata
);

   hfa_pkg::cmd_type cmd;
   hfa_pkg::sts_type sts;

   hfa_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   hfa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- sim/tb_top.sv -----
// testbench for the first-fit / best-fit contiguous allocator
`timescale 1ns / 1ps

module tb_top;

   localparam int PHASES         = 15;
   localparam int ITEMS_PER_SIZE = 30;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 24;

   typedef struct {
      hfa_pkg::req_type req;
      bit               typed;
      hfa_pkg::rsp_type outcome;
   } alloc_case_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          start;
   logic                          busy;
   hfa_pkg::req_type              req_data;
   logic                          rsp_valid;
   hfa_pkg::rsp_type              rsp_data;
   logic                          csr_we;
   logic [hfa_pkg::ADDR_BITS-1:0] csr_wdata;

   // shadow allocation table, kept sorted by base address
   logic [hfa_pkg::ID_BITS-1:0]   tbl_id    [hfa_pkg::MAX_BLOCKS];
   logic [hfa_pkg::ADDR_BITS-1:0] tbl_base  [hfa_pkg::MAX_BLOCKS];
   logic [hfa_pkg::ADDR_BITS-1:0] tbl_limit [hfa_pkg::MAX_BLOCKS];
   int unsigned                   tbl_count;
   logic [hfa_pkg::ADDR_BITS-1:0] mem_size;
   logic [hfa_pkg::ADDR_BITS-1:0] free_units;

   hfa_pkg::rsp_type awaited_placements[$];
   alloc_case_type   directed_cases[$];
   int               mismatch_count;
   int               idle_cycles;
   bit               back_to_back;

   hole_fit_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic void clear_shadow(input logic [hfa_pkg::ADDR_BITS-1:0] new_size);
      mem_size   = new_size;
      tbl_count  = 0;
      free_units = new_size;
   endfunction

   function automatic hfa_pkg::rsp_type predict_placement(input hfa_pkg::req_type r);
      hfa_pkg::rsp_type              o;
      logic [hfa_pkg::ADDR_BITS-1:0] bound;
      logic [hfa_pkg::ADDR_BITS-1:0] room;
      logic [hfa_pkg::ADDR_BITS-1:0] best_room;
      int unsigned                   chosen;
      int unsigned                   slot;
      bit                            found;
      o = '0;
      o.status = hfa_pkg::ST_OK;
      if (r.block_size > free_units) begin
         o.status    = hfa_pkg::ST_TOO_BIG;
         o.free_left = free_units;
         return o;
      end
      // empty table: placed at address zero, no id or hole checks
      if (tbl_count == 0) begin
         tbl_id[0]    = r.block_id;
         tbl_base[0]  = '0;
         tbl_limit[0] = r.block_size;
         tbl_count    = 1;
         free_units   = free_units - r.block_size;
         o.block_end  = r.block_size;
         o.free_left  = free_units;
         return o;
      end
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_id[i] == r.block_id) begin
            o.status    = hfa_pkg::ST_ID_EXISTS;
            o.free_left = free_units;
            return o;
         end
      end
      if (tbl_count >= hfa_pkg::MAX_BLOCKS) begin
         o.status    = hfa_pkg::ST_FULL;
         o.free_left = free_units;
         return o;
      end
      found     = 1'b0;
      chosen    = 0;
      best_room = '0;
      for (int i = 0; i < tbl_count; i++) begin
         bound = (i + 1 < tbl_count) ? tbl_base[i+1] : mem_size;
         room  = (bound >= tbl_limit[i]) ? bound - tbl_limit[i] : '0;
         if (room >= r.block_size && (!found || (r.command && room < best_room))) begin
            found     = 1'b1;
            chosen    = i;
            best_room = room;
            if (!r.command)
               break;
         end
      end
      if (!found) begin
         o.status    = hfa_pkg::ST_NO_HOLE;
         o.free_left = free_units;
         return o;
      end
      slot = chosen + 1;
      for (int i = tbl_count; i > slot; i--) begin
         tbl_id[i]    = tbl_id[i-1];
         tbl_base[i]  = tbl_base[i-1];
         tbl_limit[i] = tbl_limit[i-1];
      end
      tbl_id[slot]    = r.block_id;
      tbl_base[slot]  = tbl_limit[chosen];
      tbl_limit[slot] = tbl_limit[chosen] + r.block_size;
      tbl_count++;
      free_units    = free_units - r.block_size;
      o.block_start = tbl_base[slot];
      o.block_end   = tbl_limit[slot];
      o.free_left   = free_units;
      return o;
   endfunction

   function automatic hfa_pkg::req_type draw_request();
      hfa_pkg::req_type r;
      int unsigned      pick;
      r.command = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 12 && tbl_count > 0)
         r.block_id = tbl_id[$urandom_range(0, tbl_count - 1)];
      else
         r.block_id = hfa_pkg::ID_BITS'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 10)
         r.block_size = '0;
      else if (pick < 17)
         r.block_size = free_units;
      else if (pick < 24)
         r.block_size = free_units + 1'b1;
      else if (pick < 30)
         r.block_size = hfa_pkg::ADDR_BITS'($urandom_range(0, 65535));
      else
         r.block_size = hfa_pkg::ADDR_BITS'($urandom_range(0, mem_size / 10 + 1));
      return r;
   endfunction

   task automatic add_case(input logic cmd, input int id, input int sz, input bit typed,
                           input logic [hfa_pkg::STS_BITS-1:0] st, input int lo,
                           input int hi, input int left);
      alloc_case_type c;
      c.req.command         = cmd;
      c.req.block_id        = hfa_pkg::ID_BITS'(id);
      c.req.block_size      = hfa_pkg::ADDR_BITS'(sz);
      c.typed               = typed;
      c.outcome.status      = st;
      c.outcome.block_start = hfa_pkg::ADDR_BITS'(lo);
      c.outcome.block_end   = hfa_pkg::ADDR_BITS'(hi);
      c.outcome.free_left   = hfa_pkg::ADDR_BITS'(left);
      directed_cases.push_back(c);
   endtask

   task automatic issue_request(input hfa_pkg::req_type r, input bit typed,
                                input hfa_pkg::rsp_type typed_rsp);
      int               gap;
      hfa_pkg::rsp_type predicted;
      gap = back_to_back ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = predict_placement(r);
      awaited_placements.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic write_size(input logic [hfa_pkg::ADDR_BITS-1:0] value);
      start <= 1'b0;
      while (awaited_placements.size() != 0 || busy !== 1'b0)
         @(posedge clock);
      repeat (2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      clear_shadow(value);
   endtask

   always @(posedge clock) begin : check_results
      hfa_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (awaited_placements.size() == 0) begin
            $error("result with no request outstanding: %p", rsp_data);
            mismatch_count++;
         end else begin
            want = awaited_placements.pop_front();
            if (rsp_data.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.block_start !== want.block_start) begin
               $error("block_start: expected %0d, got %0d", want.block_start,
                      rsp_data.block_start);
               mismatch_count++;
            end
            if (rsp_data.block_end !== want.block_end) begin
               $error("block_end: expected %0d, got %0d", want.block_end, rsp_data.block_end);
               mismatch_count++;
            end
            if (rsp_data.free_left !== want.free_left) begin
               $error("free_left: expected %0d, got %0d", want.free_left, rsp_data.free_left);
               mismatch_count++;
            end
         end
      end
   end

   // counts cycles with neither a request nor a result transfer
   always @(posedge clock) begin
      if (reset || (start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [hfa_pkg::ADDR_BITS-1:0] new_size;
      hfa_pkg::rsp_type              unused_rsp;
      reset          <= 1'b1;
      start          <= 1'b0;
      req_data       <= '0;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      mismatch_count = 0;
      idle_cycles    = 0;
      back_to_back   = 1'b0;
      unused_rsp     = '0;
      clear_shadow(hfa_pkg::TOTAL_RESET);

      // memory of 1024 after reset; oversize is checked before the id
      add_case(1'b0, 8'hA5, 16'hFFFF, 1, hfa_pkg::ST_TOO_BIG, 0, 0, 1024);
      add_case(1'b1, 0, 1025, 1, hfa_pkg::ST_TOO_BIG, 0, 0, 1024);
      add_case(1'b0, 0, 100, 1, hfa_pkg::ST_OK, 0, 100, 924);
      add_case(1'b0, 0, 10, 1, hfa_pkg::ST_ID_EXISTS, 0, 0, 924);
      add_case(1'b1, 0, 925, 1, hfa_pkg::ST_TOO_BIG, 0, 0, 924);
      // zero sized blocks leave empty holes that best-fit prefers
      add_case(1'b1, 255, 0, 0, hfa_pkg::ST_OK, 0, 0, 0);
      add_case(1'b1, 1, 0, 0, hfa_pkg::ST_OK, 0, 0, 0);
      add_case(1'b0, 2, 0, 0, hfa_pkg::ST_OK, 0, 0, 0);
      for (int i = 3; i <= 14; i++)
         add_case(1'(i % 2), i, 10, 0, hfa_pkg::ST_OK, 0, 0, 0);
      // sixteen entries now, 804 units free
      add_case(1'b1, 200, 1, 1, hfa_pkg::ST_FULL, 0, 0, 804);
      add_case(1'b0, 14, 1, 1, hfa_pkg::ST_ID_EXISTS, 0, 0, 804);
      add_case(1'b0, 15, 805, 1, hfa_pkg::ST_TOO_BIG, 0, 0, 804);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_cases[k])
         issue_request(directed_cases[k].req, directed_cases[k].typed,
                       directed_cases[k].outcome);

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: new_size = 16'hFFFF;
            1: new_size = '0;
            2: new_size = 16'd1;
            3: new_size = 16'd300;
            4: new_size = hfa_pkg::TOTAL_RESET;
            default: begin
               if ($urandom_range(0, 1))
                  new_size = hfa_pkg::ADDR_BITS'($urandom_range(16, 2000));
               else
                  new_size = hfa_pkg::ADDR_BITS'($urandom);
            end
         endcase
         write_size(new_size);
         back_to_back = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_SIZE; n++)
            issue_request(draw_request(), 1'b0, unused_rsp);
      end
      start <= 1'b0;

      while (awaited_placements.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_placements.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/hfa_pkg.sv
rtl/core/hfa_table.sv
rtl/core/hfa_datapath.sv
rtl/core/hfa_controller.sv
rtl/core/hole_fit_allocator.sv
sim/tb_top.sv
